// ----- design/first_fit_page_allocator_defines.svh -----
// Assertion macros for the first-fit page allocator.
// Used by the top level; the asserting module supplies clk and rst.
`ifndef FIRST_FIT_PAGE_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_PAGE_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define FFPA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FFPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/ffpa_pkg.sv -----
// Shared types and constants of the first-fit page allocator.
// No dependencies; imported by the controller, datapath and top level.
package ffpa_pkg;

  localparam int BASE_W  = 20;
  localparam int COUNT_W = 11;
  localparam int ADDR_W  = 32;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic REG_BASE  = 1'b0;
  localparam logic REG_COUNT = 1'b1;

  typedef logic [1:0] flags_t;
  localparam flags_t FLAG_FREE  = 2'b00;
  localparam flags_t FLAG_TAKEN = 2'b01;
  localparam flags_t FLAG_LAST  = 2'b10;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NOROOM  = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_A_CHK,
    S_A_SCAN,
    S_A_MARK,
    S_F_CHK,
    S_F_EVAL,
    S_F_WALK
  } state_t;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_INC,
    PTR_ISSUE,
    PTR_FIRST,
    PTR_IDX
  } ptr_op_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_CLEAR,
    WR_MARK,
    WR_WALK
  } wr_sel_t;

  typedef struct packed {
    logic    load;
    ptr_op_t ptr_op;
    wr_sel_t wr_sel;
    logic    finish;
    status_t fin_status;
    logic    fin_alloc;
  } ctl_t;

  typedef struct packed {
    logic want_zero;
    logic want_big;
    logic found;
    logic scan_end;
    logic walk_stop;
    logic mark_last;
    logic clr_last;
    logic free_bad;
  } dp_stat_t;

endpackage

// ----- design/ffpa_ctrl.sv -----
// Controller state machine of the first-fit page allocator.
// Depends on ffpa_pkg; drives the datapath through ctl_t, reads dp_stat_t.
module ffpa_ctrl import ffpa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic     op,
  input  dp_stat_t stat,
  output ctl_t     ctl,
  output logic     busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_next = (op == CMD_FREE) ? S_F_CHK : S_A_CHK;
      end
      S_A_CHK: begin
        state_next = (stat.want_zero || stat.want_big) ? S_IDLE : S_A_SCAN;
      end
      S_A_SCAN: begin
        if (stat.found) state_next = S_A_MARK;
        else if (stat.scan_end) state_next = S_IDLE;
      end
      S_A_MARK: begin
        if (stat.mark_last) state_next = S_IDLE;
      end
      S_F_CHK: begin
        state_next = S_F_EVAL;
      end
      S_F_EVAL: begin
        state_next = stat.free_bad ? S_IDLE : S_F_WALK;
      end
      S_F_WALK: begin
        if (stat.walk_stop || stat.scan_end) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl.load       = 1'b0;
    ctl.ptr_op     = PTR_HOLD;
    ctl.wr_sel     = WR_NONE;
    ctl.finish     = 1'b0;
    ctl.fin_status = ST_DONE;
    ctl.fin_alloc  = 1'b0;
    case (state)
      S_CLEAR: begin
        ctl.ptr_op = PTR_INC;
        ctl.wr_sel = WR_CLEAR;
      end
      S_IDLE: begin
        ctl.load   = start;
        ctl.ptr_op = PTR_ZERO;
      end
      S_A_CHK: begin
        if (stat.want_zero) begin
          ctl.finish     = 1'b1;
          ctl.fin_status = ST_INVALID;
        end else if (stat.want_big) begin
          ctl.finish     = 1'b1;
          ctl.fin_status = ST_NOROOM;
        end
      end
      S_A_SCAN: begin
        ctl.ptr_op = stat.found ? PTR_FIRST : PTR_ISSUE;
        if (!stat.found && stat.scan_end) begin
          ctl.finish     = 1'b1;
          ctl.fin_status = ST_NOROOM;
        end
      end
      S_A_MARK: begin
        ctl.ptr_op = PTR_INC;
        ctl.wr_sel = WR_MARK;
        if (stat.mark_last) begin
          ctl.finish    = 1'b1;
          ctl.fin_alloc = 1'b1;
        end
      end
      S_F_CHK: begin
        ctl.ptr_op = PTR_HOLD;
      end
      S_F_EVAL: begin
        if (stat.free_bad) begin
          ctl.finish     = 1'b1;
          ctl.fin_status = ST_INVALID;
        end else begin
          ctl.ptr_op = PTR_IDX;
        end
      end
      S_F_WALK: begin
        ctl.ptr_op = PTR_ISSUE;
        ctl.wr_sel = WR_WALK;
        ctl.finish = stat.walk_stop || stat.scan_end;
      end
      default: begin
        ctl.ptr_op = PTR_HOLD;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// ----- design/ffpa_dp.sv -----
// Datapath of the first-fit page allocator: page flag memory, scan pointer,
// run counter, address checks and result registers. Depends on ffpa_pkg.
module ffpa_dp import ffpa_pkg::*; #(
  parameter int MAX_PAGES  = 1024,
  parameter int PAGE_SHIFT = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic               wr_index,
  input  logic [BASE_W-1:0]  wr_data,
  input  logic [COUNT_W-1:0] pages_wanted,
  input  logic [ADDR_W-1:0]  free_address,
  input  ctl_t               ctl,
  output dp_stat_t           stat,
  output logic               done,
  output logic [ADDR_W-1:0]  block_address,
  output logic [1:0]         status
);

  localparam int IW = $clog2(MAX_PAGES);
  localparam int CW = $clog2(MAX_PAGES + 1);
  localparam int NW = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int AW = ((BASE_W + PAGE_SHIFT > ADDR_W) ? BASE_W + PAGE_SHIFT : ADDR_W) + 1;
  localparam int SW = ((CW > BASE_W) ? CW : BASE_W) + 1;

  logic [BASE_W-1:0]  base_page;
  logic [COUNT_W-1:0] page_count;
  logic [CW-1:0]      count_c;

  logic [COUNT_W-1:0] want_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [AW-1:0]      lo_c;
  logic [AW-1:0]      hi_r;
  logic [AW-1:0]      diff_r;

  flags_t             mem [MAX_PAGES];
  flags_t             rd_data;
  logic [CW-1:0]      rd_idx;
  logic               rd_vld;
  logic [CW-1:0]      ptr;
  logic [CW-1:0]      end_r;
  logic [CW-1:0]      first_r;
  logic [CW-1:0]      first_c;
  logic [CW-1:0]      run;
  logic               issue;
  logic               taken;
  logic               last;

  logic               we;
  logic [IW-1:0]      waddr;
  flags_t             wdata;

  logic [SW-1:0]      page_sum;
  logic [ADDR_W-1:0]  alloc_addr;

  assign count_c = (NW'(page_count) < NW'(MAX_PAGES)) ? CW'(page_count) : CW'(MAX_PAGES);
  assign issue   = (ptr < count_c);
  assign taken   = |(rd_data & FLAG_TAKEN);
  assign last    = |(rd_data & FLAG_LAST);
  assign first_c = CW'(NW'(rd_idx) + NW'(1) - NW'(want_r));
  assign lo_c    = AW'(base_page) << PAGE_SHIFT;

  assign page_sum   = SW'(base_page) + SW'(first_r);
  assign alloc_addr = ADDR_W'({page_sum, {PAGE_SHIFT{1'b0}}});

  assign stat.want_zero = (want_r == '0);
  assign stat.want_big  = (NW'(want_r) > NW'(count_c));
  assign stat.found     = rd_vld && !taken && ((NW'(run) + NW'(1)) == NW'(want_r));
  assign stat.scan_end  = !rd_vld && !issue;
  assign stat.walk_stop = rd_vld && (!taken || last);
  assign stat.mark_last = (ptr == end_r);
  assign stat.clr_last  = (ptr == CW'(MAX_PAGES - 1));
  assign stat.free_bad  = (addr_r == '0) || diff_r[AW-1] || (AW'(addr_r) >= hi_r);

  always_comb begin
    we    = 1'b0;
    waddr = ptr[IW-1:0];
    wdata = FLAG_FREE;
    case (ctl.wr_sel)
      WR_CLEAR: begin
        we = 1'b1;
      end
      WR_MARK: begin
        we    = 1'b1;
        wdata = (ptr == end_r) ? (FLAG_TAKEN | FLAG_LAST) : FLAG_TAKEN;
      end
      WR_WALK: begin
        we    = rd_vld && taken;
        waddr = rd_idx[IW-1:0];
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if ((ctl.ptr_op == PTR_ISSUE) && issue) rd_data <= mem[ptr[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_page  <= '0;
      page_count <= '0;
      ptr        <= '0;
      rd_vld     <= 1'b0;
      run        <= '0;
      done       <= 1'b0;
    end else begin
      if (wr_en && (wr_index == REG_BASE)) base_page <= wr_data;
      if (wr_en && (wr_index == REG_COUNT)) page_count <= wr_data[COUNT_W-1:0];
      rd_vld <= (ctl.ptr_op == PTR_ISSUE) && issue;
      done   <= ctl.finish;
      case (ctl.ptr_op)
        PTR_ZERO:  ptr <= '0;
        PTR_INC:   ptr <= ptr + CW'(1);
        PTR_ISSUE: if (issue) ptr <= ptr + CW'(1);
        PTR_FIRST: ptr <= first_c;
        PTR_IDX:   ptr <= diff_r[PAGE_SHIFT +: CW];
        default:   ptr <= ptr;
      endcase
      if (ctl.ptr_op == PTR_ZERO) begin
        run <= '0;
      end else if ((ctl.ptr_op == PTR_ISSUE) && rd_vld) begin
        run <= taken ? '0 : run + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      want_r <= pages_wanted;
      addr_r <= free_address;
    end
    hi_r   <= lo_c + (AW'(count_c) << PAGE_SHIFT);
    diff_r <= AW'(addr_r) - lo_c;
    if ((ctl.ptr_op == PTR_ISSUE) && issue) rd_idx <= ptr;
    if (ctl.ptr_op == PTR_FIRST) begin
      end_r   <= rd_idx;
      first_r <= first_c;
    end
    if (ctl.finish) begin
      block_address <= ctl.fin_alloc ? alloc_addr : '0;
      status        <= ctl.fin_status;
    end
  end

endmodule

// ----- design/first_fit_page_allocator.sv -----
// Allocate: a first-fit scan of the pages in use, then marking of the found run, up to the
// done strobe; a failed scan reports no room. Free: the taken pages of the block are cleared
// until the walk meets a free page, a page flagged last or the table end; rejects end early.
// One flag memory read and one write per cycle; one word at a time.
// Reset: synchronous; a clearing pass over all MAX_PAGES pages runs with busy high.
// The done strobe lasts one cycle and cannot be stalled by the receiver.
`include "first_fit_page_allocator_defines.svh"
module first_fit_page_allocator import ffpa_pkg::*; #(
  parameter int MAX_PAGES  = 1024,
  parameter int PAGE_SHIFT = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic               wr_index,
  input  logic [BASE_W-1:0]  wr_data,
  input  logic               start,
  output logic               busy,
  input  logic               cmd,
  input  logic [COUNT_W-1:0] pages_wanted,
  input  logic [ADDR_W-1:0]  free_address,
  output logic               done,
  output logic [ADDR_W-1:0]  block_address,
  output logic [1:0]         status
);

  ctl_t     ctl;
  dp_stat_t stat;

  ffpa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (cmd),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy)
  );

  ffpa_dp #(
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .wr_en         (wr_en),
    .wr_index      (wr_index),
    .wr_data       (wr_data),
    .pages_wanted  (pages_wanted),
    .free_address  (free_address),
    .ctl           (ctl),
    .stat          (stat),
    .done          (done),
    .block_address (block_address),
    .status        (status)
  );

  `FFPA_ASSERT_NOW(a_done_after_busy, done, $past(busy), "result without a request in flight")
  `FFPA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
  `FFPA_ASSERT_NOW(a_fail_zero_addr, done && (status != ST_DONE), block_address == '0, "failed result carries an address")
  `FFPA_ASSERT_NOW(a_status_code, done, (status == ST_DONE) || (status == ST_NOROOM) || (status == ST_INVALID), "bad status code")

endmodule
